@@ rtl/core/xrr_pkg.sv @@
package xrr_pkg;

    localparam int WORD_W   = 32;
    localparam int KIND_W   = 2;
    localparam int STEP_W   = 5;

    localparam logic [WORD_W-1:0] MIX_MULT = 32'h9E37_79BB;
    localparam logic [WORD_W-1:0] WORD_RESET = 32'd1;

    localparam logic [KIND_W-1:0] KIND_RAW   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RANGE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BIT   = 2'd2;

    typedef logic [WORD_W-1:0] word_t;

    function automatic word_t rotl32(input word_t v, input int unsigned n);
        word_t r;
        r = (v << n) | (v >> (WORD_W - n));
        return r;
    endfunction

endpackage

@@ rtl/core/xrr_divider.sv @@
module xrr_divider
    import xrr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t dividend,
    input  word_t divisor,
    output logic  done,
    output word_t remainder
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] count_reg, count_next;
    word_t             rem_reg, rem_next;
    word_t             dvd_reg, dvd_next;
    word_t             dvs_reg, dvs_next;

    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   trial;

    // one restoring step per cycle, msb first
    assign shifted = {rem_reg, dvd_reg[WORD_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '1;
            rem_next   = '0;
            dvd_next   = dividend;
            dvs_next   = divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            if (!trial[WORD_W])
                rem_next = trial[WORD_W-1:0];
            else
                rem_next = shifted[WORD_W-1:0];
            count_next = count_reg - 1'b1;
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/core/xoroshiro64ss_ranged_random.sv @@
// channel   direction  handshake              payload
// request   in         in_valid / in_stall    kind, low_bound, high_bound
// result    out        out_valid / out_stall  value, span_zero
// seed      in         seed_write             seed_value
//
// Raw and bit draws pass from the accepted beat through the mix, draw and finish states to the result beat.
// Ranged draws with non-zero span also wait in the divide state for the 32-step remainder unit.
// One request at a time; in_stall is high from acceptance until the result is in
// the output register. A stalled result holds; the next request is taken meanwhile.
// Reset sets both state words to 1.
module xoroshiro64ss_ranged_random
    import xrr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              seed_write,
    input  word_t             seed_value,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [KIND_W-1:0] kind,
    input  word_t             low_bound,
    input  word_t             high_bound,
    output logic              out_valid,
    input  logic              out_stall,
    output word_t             value,
    output logic              span_zero
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MIX  = 3'd1;
    localparam logic [2:0] ST_DRAW = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]        state_reg, state_next;
    word_t             word_a_reg, word_a_next;
    word_t             word_b_reg, word_b_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    word_t             lo_reg, lo_next;
    word_t             span_reg, span_next;
    word_t             prod_reg, prod_next;
    word_t             draw_reg, draw_next;
    word_t             res_reg, res_next;
    logic              flag_reg, flag_next;
    logic              out_valid_reg, out_valid_next;
    word_t             value_reg, value_next;
    logic              span_zero_reg, span_zero_next;

    logic              accept;
    logic              out_take;
    word_t             s1x;
    word_t             rot;
    logic              div_start;
    logic              div_done;
    word_t             div_rem;

    assign accept   = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != ST_IDLE);

    assign s1x = word_b_reg ^ word_a_reg;
    assign rot = rotl32(prod_reg, 5);

    always_comb
    begin
        state_next     = state_reg;
        word_a_next    = word_a_reg;
        word_b_next    = word_b_reg;
        kind_next      = kind_reg;
        lo_next        = lo_reg;
        span_next      = span_reg;
        prod_next      = prod_reg;
        draw_next      = draw_reg;
        res_next       = res_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        span_zero_next = span_zero_reg;
        div_start      = 1'b0;

        if (out_take)
            out_valid_next = 1'b0;

        if (seed_write)
        begin
            word_a_next = seed_value + WORD_RESET;
            word_b_next = seed_value + WORD_RESET;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next   = kind;
                    lo_next     = low_bound;
                    span_next   = high_bound - low_bound;
                    prod_next   = word_a_reg * MIX_MULT;
                    word_a_next = rotl32(word_a_reg, 26) ^ s1x ^ (s1x << 9);
                    word_b_next = rotl32(s1x, 13);
                    state_next  = ST_MIX;
                end
            end
            ST_MIX:
            begin
                draw_next  = rot + (rot << 2);
                state_next = ST_DRAW;
            end
            ST_DRAW:
            begin
                flag_next = 1'b0;
                res_next  = draw_reg;
                if (kind_reg == KIND_RANGE)
                begin
                    if (span_reg == '0)
                    begin
                        res_next   = lo_reg;
                        flag_next  = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
                else
                begin
                    if (kind_reg == KIND_BIT)
                        res_next = {{(WORD_W-1){1'b0}}, draw_reg[0]};
                    state_next = ST_FIN;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_rem + lo_reg;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    value_next     = res_reg;
                    span_zero_next = flag_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    xrr_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (draw_reg),
        .divisor   (span_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            word_a_reg    <= WORD_RESET;
            word_b_reg    <= WORD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_a_reg    <= word_a_next;
            word_b_reg    <= word_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        lo_reg        <= lo_next;
        span_reg      <= span_next;
        prod_reg      <= prod_next;
        draw_reg      <= draw_next;
        res_reg       <= res_next;
        flag_reg      <= flag_next;
        value_reg     <= value_next;
        span_zero_reg <= span_zero_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign span_zero = span_zero_reg;

    a_accept_to_mix: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_MIX)
        else $error("accepted beat did not start the draw");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("remainder unit finished outside the divide phase");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(state_reg) == ST_FIN)
        else $error("result beat raised without a finished draw");

endmodule

@@ tb/sv/tb_xoroshiro64ss_ranged_random.sv @@
module tb_xoroshiro64ss_ranged_random;
    import xrr_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_PAUSE = 60;

    typedef struct {
        word_t value;
        logic  span_zero;
    } draw_t;

    // Tracks the generator state and the draws still owed by the block.
    class rng_scoreboard;
        word_t word_a;
        word_t word_b;
        draw_t pending_draws[$];
        int    errors;

        function new();
            word_a = WORD_RESET;
            word_b = WORD_RESET;
            errors = 0;
        endfunction

        function void reseed(word_t seed);
            word_a = seed + 32'd1;
            word_b = seed + 32'd1;
        endfunction

        function int pending();
            return pending_draws.size();
        endfunction

        function void flag_error(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void note_request(logic [KIND_W-1:0] k, word_t lo, word_t hi);
            word_t s0, s1, prod, mixed, draw, span;
            draw_t d;
            s0    = word_a;
            s1    = word_b;
            prod  = s0 * MIX_MULT;
            mixed = {prod[26:0], prod[31:27]};
            draw  = mixed * 32'd5;
            s1    = s1 ^ s0;
            word_a = {s0[5:0], s0[31:6]} ^ s1 ^ (s1 << 9);
            word_b = {s1[18:0], s1[31:19]};
            d.value     = draw;
            d.span_zero = 1'b0;
            if (k == KIND_RANGE)
            begin
                span = hi - lo;
                if (span == 32'd0)
                begin
                    d.value     = lo;
                    d.span_zero = 1'b1;
                end
                else
                    d.value = (draw % span) + lo;
            end
            else if (k == KIND_BIT)
                d.value = {31'd0, draw[0]};
            pending_draws.push_back(d);
        endfunction

        function void check_result(word_t v, logic f);
            draw_t d;
            if (pending_draws.size() == 0)
            begin
                flag_error($sformatf("result beat value=%h span_zero=%b with nothing pending",
                                     v, f));
                return;
            end
            d = pending_draws.pop_front();
            if (v !== d.value)
                flag_error($sformatf("value expected %h actual %h", d.value, v));
            if (f !== d.span_zero)
                flag_error($sformatf("span_zero expected %b actual %b", d.span_zero, f));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              seed_write = 1'b0;
    word_t             seed_value = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [KIND_W-1:0] kind = KIND_RAW;
    word_t             low_bound = '0;
    word_t             high_bound = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    word_t             value;
    logic              span_zero;

    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    logic          out_hold = 1'b0;
    int unsigned   cycle_count = 0;
    rng_scoreboard sb;

    xoroshiro64ss_ranged_random DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_write (seed_write),
        .seed_value (seed_value),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .low_bound  (low_bound),
        .high_bound (high_bound),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .span_zero  (span_zero)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (out_hold)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_request(kind, low_bound, high_bound);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(value, span_zero);
    end

    task automatic send_request(input logic [KIND_W-1:0] k, input word_t lo, input word_t hi);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        kind       = k;
        low_bound  = lo;
        high_bound = hi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic load_seed(input word_t seed);
        wait_drained();
        @(negedge clk);
        seed_write = 1'b1;
        seed_value = seed;
        sb.reseed(seed);
        @(negedge clk);
        seed_write = 1'b0;
    endtask

    task automatic send_random(input int count);
        logic [KIND_W-1:0] k;
        word_t             lo, hi;
        int                pick;
        repeat (count)
        begin
            pick = $urandom_range(9);
            if (pick < 2)
                k = KIND_RAW;
            else if (pick < 7)
                k = KIND_RANGE;
            else if (pick < 9)
                k = KIND_BIT;
            else
                k = KIND_SPARE;
            lo = $urandom;
            case ($urandom_range(9))
                0, 1, 2: hi = lo + $urandom_range(100, 1);
                3, 4:    hi = $urandom;
                5:       hi = lo;
                6:       hi = lo + (32'd1 << $urandom_range(31));
                7:       hi = lo - $urandom_range(1000, 1);
                8:
                begin
                    lo = $urandom_range(50);
                    hi = $urandom_range(50);
                end
                default: hi = ($urandom_range(1)) ? lo + 32'd1 : lo + 32'hFFFF_FFFF;
            endcase
            send_request(k, lo, hi);
        end
    endtask

    initial
    begin
        sb = new();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // reset state, no seed written yet
        send_request(KIND_RAW,   32'h0000_0000, 32'h0000_0000);
        send_request(KIND_BIT,   32'h0000_0000, 32'h0000_0000);
        send_request(KIND_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_RANGE, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(KIND_RANGE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(KIND_RANGE, 32'h0000_0000, 32'h0000_0000);
        send_request(KIND_RANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_RANGE, 32'h1234_5678, 32'h1234_5679);
        send_request(KIND_RANGE, 32'h0000_000A, 32'h0000_0005);
        send_request(KIND_RANGE, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(KIND_RANGE, 32'h0000_0003, 32'h0000_000A);
        send_request(KIND_RANGE, 32'hFFFF_FFF0, 32'h0000_0010);
        send_request(KIND_BIT,   32'hFFFF_FFFF, 32'h0000_0000);
        send_request(KIND_RAW,   32'hFFFF_FFFF, 32'hFFFF_FFFF);

        load_seed(32'h0000_0000);
        send_random(175);

        load_seed(32'hFFFF_FFFF);
        send_idle_pct = 52;
        send_random(175);

        // seed+1 is all ones: all-ones generator state
        load_seed(32'hFFFF_FFFE);
        send_idle_pct = 0;
        send_random(20);

        load_seed($urandom);
        recv_stall_pct = 52;
        send_random(175);

        load_seed($urandom);
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        send_random(175);

        // long receiver hold-off with the sender pushing back to back
        load_seed($urandom);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                @(posedge clk);
                out_hold = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_hold = 1'b0;
            end
            send_random(12);
        join

        wait_drained();
        repeat (DRAIN_PAUSE) @(posedge clk);
        if (sb.pending() != 0)
            sb.flag_error($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/xrr_pkg.sv
rtl/core/xrr_divider.sv
rtl/core/xoroshiro64ss_ranged_random.sv
tb/sv/tb_xoroshiro64ss_ranged_random.sv
